// ===== sv/dctd_pkg.sv =====
// Shared types and constants for the double-clap toggle detector.
package dctd_pkg;

  localparam int STAMP_W = 32;
  localparam int GAP_W   = 16;
  localparam int PADDR_W = 3;

  localparam logic [GAP_W-1:0] MIN_GAP_RESET = 16'd400;
  localparam logic [GAP_W-1:0] MAX_GAP_RESET = 16'd1000;

  // Register select, taken from paddr[2]
  localparam logic REG_MIN_GAP = 1'b0;
  localparam logic REG_MAX_GAP = 1'b1;

  // Write and clear controls from the sequencer to the ring store
  typedef struct packed {
    logic wr_en;
    logic clear;
  } ring_ctl_t;

  // One result
  typedef struct packed {
    logic load_on;
    logic toggled;
  } result_t;

endpackage

// ===== sv/dctd_ring.sv =====
// Timestamp ring store: one write port, two registered read ports, per-entry valid bits.
module dctd_ring
  import dctd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ring_ctl_t                     ctl,
  input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  input  logic [STAMP_W-1:0]            wr_data,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_a_addr,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_b_addr,
  output logic [STAMP_W-1:0]            rd_a_data,
  output logic [STAMP_W-1:0]            rd_b_data
);

  logic [STAMP_W-1:0]    mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid;
  logic [STAMP_W-1:0]    rd_a_q;
  logic [STAMP_W-1:0]    rd_b_q;
  logic                  rd_a_vld;
  logic                  rd_b_vld;

  // Write the stamp
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register both reads together with their valid bits
  always_ff @(posedge clk) begin
    rd_a_q   <= mem[rd_a_addr];
    rd_b_q   <= mem[rd_b_addr];
    rd_a_vld <= valid[rd_a_addr];
    rd_b_vld <= valid[rd_b_addr];
  end

  // Drop every entry at once on reset or clear; mark entries as written
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // An entry never written since the last clear reads as zero
  assign rd_a_data = rd_a_vld ? rd_a_q : '0;
  assign rd_b_data = rd_b_vld ? rd_b_q : '0;

endmodule

// ===== sv/dctd_ctrl.sv =====
// Sequencer: duplicate check, ring update, pair walk and load toggle.
module dctd_ctrl
  import dctd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [STAMP_W-1:0]            event_time_ms,
  input  logic [GAP_W-1:0]              min_gap_ms,
  input  logic [GAP_W-1:0]              max_gap_ms,
  output ring_ctl_t                     ring_ctl,
  output logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  output logic [STAMP_W-1:0]            wr_data,
  output logic [$clog2(RING_DEPTH)-1:0] rd_a_addr,
  output logic [$clog2(RING_DEPTH)-1:0] rd_b_addr,
  input  logic [STAMP_W-1:0]            rd_a_data,
  input  logic [STAMP_W-1:0]            rd_b_data,
  output logic                          res_valid,
  output result_t                       res,
  input  logic                          res_ready
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state;
  logic [STAMP_W-1:0] stamp;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      pos_inc;
  logic               load_state;
  logic               flip;
  logic [AW-1:0]      scan_i;
  logic [AW-1:0]      scan_j;
  logic               issue_done;
  logic               cmp_vld;
  logic               cmp_last;
  logic               scan_last;
  logic               dup;
  logic [STAMP_W-1:0] gap;
  logic               hit;

  assign in_stall  = (state != ST_IDLE);
  assign pos_inc   = (pos == LAST_IDX) ? '0 : pos + 1'b1;
  assign scan_last = (scan_i == LAST_IDX) && (scan_j == LAST_IDX);

  // Entry at the current position arrives in the cycle after acceptance
  assign dup = (rd_a_data == stamp);

  // Pair difference, wrapping at 2^32, against the open window
  assign gap = rd_b_data - rd_a_data;
  assign hit = cmp_vld && (gap > STAMP_W'(min_gap_ms)) && (gap < STAMP_W'(max_gap_ms));

  // Ring port drive
  assign rd_a_addr      = (state == ST_IDLE) ? pos : scan_i;
  assign rd_b_addr      = scan_j;
  assign wr_addr        = pos_inc;
  assign wr_data        = stamp;
  assign ring_ctl.wr_en = (state == ST_CHECK) && !dup;
  assign ring_ctl.clear = (state == ST_SCAN) && hit;

  assign res_valid   = (state == ST_DONE);
  assign res.load_on = load_state;
  assign res.toggled = flip;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      load_state <= 1'b0;
      flip       <= 1'b0;
      issue_done <= 1'b0;
      cmp_vld    <= 1'b0;
      cmp_last   <= 1'b0;
      scan_i     <= '0;
      scan_j     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Drop a repeated stamp, else advance and start the pair walk
          if (dup) begin
            state <= ST_IDLE;
          end else begin
            pos        <= pos_inc;
            scan_i     <= '0;
            scan_j     <= '0;
            issue_done <= 1'b0;
            cmp_vld    <= 1'b0;
            cmp_last   <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one pair a cycle
          cmp_vld  <= !issue_done;
          cmp_last <= scan_last;
          if (!issue_done) begin
            if (scan_last) begin
              issue_done <= 1'b1;
            end else if (scan_j == LAST_IDX) begin
              scan_j <= '0;
              scan_i <= scan_i + 1'b1;
            end else begin
              scan_j <= scan_j + 1'b1;
            end
          end
          // Finish on the first pair in the window or after the last pair
          if (hit) begin
            load_state <= !load_state;
            flip       <= 1'b1;
            issue_done <= 1'b1;
            cmp_vld    <= 1'b0;
            state      <= ST_DONE;
          end else if (cmp_vld && cmp_last) begin
            flip    <= 1'b0;
            cmp_vld <= 1'b0;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the request stamp
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      stamp <= event_time_ms;
    end
  end

endmodule

// ===== sv/double_clap_toggle_detector.sv =====
// Top level of the double-clap toggle detector: register port, output register, core.
//
// Each request carries a 32-bit millisecond timestamp of a sound edge. A stamp equal to the
// ring entry at the current position is dropped in the check state with no result. Any other
// stamp is written at the next ring position, and then every ordered pair of ring entries is
// checked, one pair a cycle through the two read ports of the ring store; the walk stops at
// the first pair whose wrapped difference lies strictly between min_gap_ms and max_gap_ms,
// which clears the ring and toggles the load. Each such request gives one result (load_on,
// toggled). A new request is taken while the previous result still waits in the output
// register. Reset clears the ring at once; there is no clearing pass. The gap bounds are at
// byte addresses 0 (min_gap_ms) and 4 (max_gap_ms); the user must write them only while
// idle, and the block itself does not enforce this.
module double_clap_toggle_detector
  import dctd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [STAMP_W-1:0] event_time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               load_on,
  output logic               toggled
);

  localparam int AW = $clog2(RING_DEPTH);

  logic [GAP_W-1:0]   min_gap_ms;
  logic [GAP_W-1:0]   max_gap_ms;
  logic               cfg_wr;
  ring_ctl_t          ring_ctl;
  logic [AW-1:0]      wr_addr;
  logic [STAMP_W-1:0] wr_data;
  logic [AW-1:0]      rd_a_addr;
  logic [AW-1:0]      rd_b_addr;
  logic [STAMP_W-1:0] rd_a_data;
  logic [STAMP_W-1:0] rd_b_data;
  logic               res_valid;
  result_t            res;
  logic               res_ready;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ms <= MIN_GAP_RESET;
      max_gap_ms <= MAX_GAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MIN_GAP: min_gap_ms <= pwdata[GAP_W-1:0];
        REG_MAX_GAP: max_gap_ms <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_GAP: prdata = {{(32-GAP_W){1'b0}}, min_gap_ms};
      REG_MAX_GAP: prdata = {{(32-GAP_W){1'b0}}, max_gap_ms};
      default:     prdata = '0;
    endcase
  end

  dctd_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_a_addr(rd_a_addr),
    .rd_b_addr(rd_b_addr),
    .rd_a_data(rd_a_data),
    .rd_b_data(rd_b_data)
  );

  dctd_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .event_time_ms(event_time_ms),
    .min_gap_ms   (min_gap_ms),
    .max_gap_ms   (max_gap_ms),
    .ring_ctl     (ring_ctl),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_a_addr    (rd_a_addr),
    .rd_b_addr    (rd_b_addr),
    .rd_a_data    (rd_a_data),
    .rd_b_data    (rd_b_data),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  // Output register: load a result when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      load_on <= res.load_on;
      toggled <= res.toggled;
    end
  end

endmodule

// ===== tb/dctd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the double-clap toggle detector: tracks the gap registers, predicts each result.
module dctd_checker
  import dctd_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [STAMP_W-1:0] event_time_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               load_on,
  input  logic               toggled,
  output int                 pending,
  output int                 fails
);

  // Predicted state of the detector
  logic [STAMP_W-1:0] stamps [RING_DEPTH];
  int unsigned        slot;
  logic               load;
  logic [GAP_W-1:0]   min_gap;
  logic [GAP_W-1:0]   max_gap;
  result_t            due_results [$];
  int                 err_count = 0;

  assign fails = err_count;

  // Search every ordered pair of stamps for a gap strictly inside the window
  function automatic bit clap_pair_found();
    logic [STAMP_W-1:0] gap;
    for (int i = 0; i < RING_DEPTH; i++) begin
      for (int j = 0; j < RING_DEPTH; j++) begin
        gap = stamps[j] - stamps[i];
        if (gap > STAMP_W'(min_gap) && gap < STAMP_W'(max_gap)) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Advance the ring with one stamp and queue the resulting load state
  task automatic take_stamp(input logic [STAMP_W-1:0] stamp);
    result_t res;
    // drop a repeated stamp: no result
    if (stamp == stamps[slot]) begin
      return;
    end
    slot = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
    stamps[slot] = stamp;
    res.toggled = clap_pair_found();
    if (res.toggled) begin
      foreach (stamps[k]) stamps[k] = '0;
      load = ~load;
    end
    res.load_on = load;
    due_results.push_back(res);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (stamps[k]) stamps[k] = '0;
      slot    = 0;
      load    = 1'b0;
      min_gap = MIN_GAP_RESET;
      max_gap = MAX_GAP_RESET;
      due_results.delete();
      pending <= 0;
    end else begin
      // follow register writes, check read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_MIN_GAP) begin
            min_gap = pwdata[GAP_W-1:0];
          end else begin
            max_gap = pwdata[GAP_W-1:0];
          end
        end else if (prdata[GAP_W-1:0] !==
                     ((paddr[2] == REG_MIN_GAP) ? min_gap : max_gap)) begin
          $error("prdata: expected %0d, got %0d",
                 (paddr[2] == REG_MIN_GAP) ? min_gap : max_gap, prdata[GAP_W-1:0]);
          err_count++;
        end
      end

      // compare each delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: load_on %0b, toggled %0b", load_on, toggled);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (load_on !== want.load_on) begin
            $error("load_on: expected %0b, got %0b", want.load_on, load_on);
            err_count++;
          end
          if (toggled !== want.toggled) begin
            $error("toggled: expected %0b, got %0b", want.toggled, toggled);
            err_count++;
          end
        end
      end

      // predict from each accepted request
      if (in_valid && !in_stall) begin
        take_stamp(event_time_ms);
      end
      pending <= due_results.size();
    end
  end

endmodule

// ===== tb/tb_double_clap_toggle_detector.sv =====
`timescale 1ns / 100ps
// Testbench top for the double-clap toggle detector: stimulus, gap settings and verdict.
module tb_double_clap_toggle_detector;
  import dctd_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int SETTLE      = RING_DEPTH * RING_DEPTH + 40;
  localparam int LIMIT       = 3_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 192;

  localparam logic [PADDR_W-1:0] ADDR_MIN_GAP = {REG_MIN_GAP, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_MAX_GAP = {REG_MAX_GAP, 2'b00};

  // Opening stamps: zero after reset, all-ones, repeats, window edges, wrap, bit patterns
  localparam logic [STAMP_W-1:0] OPENING [15] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd500, 32'h0000_0000,
    32'd1000, 32'd1401, 32'd400, 32'hAAAA_AAAA, 32'h5555_5555,
    32'hFFFF_FF00, 32'd300, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [STAMP_W-1:0] event_time_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               load_on;
  logic               toggled;

  int pending;
  int fails;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int win_min = int'(MIN_GAP_RESET);
  int win_max = int'(MAX_GAP_RESET);

  always #5 clk = ~clk;

  double_clap_toggle_detector #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .event_time_ms(event_time_ms),
    .out_valid(out_valid), .out_stall(out_stall), .load_on(load_on), .toggled(toggled)
  );

  dctd_checker #(.RING_DEPTH(RING_DEPTH)) u_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .event_time_ms(event_time_ms),
    .out_valid(out_valid), .out_stall(out_stall), .load_on(load_on), .toggled(toggled),
    .pending(pending), .fails(fails)
  );

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("double_clap_toggle_detector: mismatch");
      $finish;
    end
  end

  // One register access: setup cycle, then access cycle until pready
  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both gap bounds and read each back; upper data bits carry noise
  task automatic set_window(input int lo, input int hi);
    reg_access(1'b1, ADDR_MIN_GAP, {16'($urandom()), 16'(lo)});
    reg_access(1'b0, ADDR_MIN_GAP, '0);
    reg_access(1'b1, ADDR_MAX_GAP, {16'($urandom()), 16'(hi)});
    reg_access(1'b0, ADDR_MAX_GAP, '0);
    win_min = lo;
    win_max = hi;
  endtask

  // Offer one stamp request, idling first at random, and hold it until taken
  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    event_time_ms <= stamp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Wait for every result, then idle so that a last, dropped request is also through
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    logic [STAMP_W-1:0] base;
    logic [STAMP_W-1:0] gap;
    int                 sent;
    int                 pick;
    int                 lo;
    int                 hi;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed opening with the reset window
    foreach (OPENING[k]) send_stamp(OPENING[k]);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      // pick the window: extremes, empty windows, a single-value window, random
      case (phase)
        0: begin lo = 400;   hi = 1000;  end
        1: begin lo = 0;     hi = 65535; end
        2: begin lo = 65535; hi = 0;     end
        3: begin lo = 0;     hi = 2;     end
        4: begin lo = 1000;  hi = 1001;  end
        5: begin lo = 65534; hi = 65535; end
        6: begin
          lo = $urandom_range(0, 30000);
          hi = $urandom_range(lo + 2, 65535);
        end
        default: begin lo = 100; hi = 5000; end
      endcase
      set_window(lo, hi);

      // cycle the idling modes: none, sender, receiver, both
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase

      base = $urandom();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // double clap, sometimes with a bounce on the first edge
          base += $urandom_range(1, 4000);
          send_stamp(base);
          if ($urandom_range(3) == 0) begin
            send_stamp(base);
            sent++;
          end
          if (win_min + 1 < win_max) begin
            gap = $urandom_range(win_min + 1, win_max - 1);
          end else begin
            gap = $urandom_range(0, 65535);
          end
          base += gap;
          send_stamp(base);
          sent += 2;
        end else if (pick < 65) begin
          // gap on or outside a window edge
          case ($urandom_range(3))
            0: gap = win_min;
            1: gap = win_max;
            2: gap = $urandom_range(0, win_min);
            default: gap = win_max + $urandom_range(1, 70000);
          endcase
          base += gap;
          send_stamp(base);
          sent++;
        end else if (pick < 75) begin
          send_stamp('0);
          sent++;
        end else if (pick < 85) begin
          send_stamp(base);
          sent++;
        end else begin
          base = $urandom();
          send_stamp(base);
          sent++;
        end
      end
    end

    drain();
    if (fails == 0) begin
      $display("double_clap_toggle_detector: match");
    end else begin
      $display("double_clap_toggle_detector: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dctd_pkg.sv
sv/dctd_ring.sv
sv/dctd_ctrl.sv
sv/double_clap_toggle_detector.sv
tb/dctd_checker.sv
tb/tb_double_clap_toggle_detector.sv
